// File: src/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, widths and codes of the packed slot table with swap-remove.
// ----------------------------------------------------------------------------
package pst_pkg;

    // table sizes
    localparam int MAX_ENTRIES = 256;
    localparam int ID_SPACE    = 1024;

    // field widths
    localparam int ACTION_W = 2;
    localparam int ID_W     = 10;
    localparam int HANDLE_W = 9;
    localparam int STATUS_W = 2;

    // derived widths
    localparam int SLOT_W  = $clog2(MAX_ENTRIES);
    localparam int MAP_AW  = $clog2(ID_SPACE);
    localparam int COUNT_W = HANDLE_W;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_GET      = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DESTROY  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

    // request transaction
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     entity_id;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    // response transaction
    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [ID_W-1:0]     entity_out;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

// File: src/packed_slot_table_swap_remove_core.sv
// ----------------------------------------------------------------------------
// packed_slot_table_swap_remove_core
// Steps: register and a rejected get or destroy go from idle to the response
// state; find and get pass through a lookup state, destroy through two remove
// states. One transaction in flight: a new request is taken only in the idle
// state, and the response state holds while the output register is full and not
// taken; each RAM read is registered and destroy chains two packed id reads.
// Reset: count cleared, then a clearing pass writes zero to every one of the
// ID_SPACE (1024) entries of the id map, during which no request is accepted.
// ----------------------------------------------------------------------------
module packed_slot_table_swap_remove_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pst_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pst_pkg::rsp_t  rsp
);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_DEST1 = 3'd3;
    localparam logic [2:0] S_DEST2 = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    localparam logic [pst_pkg::MAP_AW-1:0] MAP_LAST =
        pst_pkg::MAP_AW'(pst_pkg::ID_SPACE - 1);
    localparam logic [pst_pkg::COUNT_W-1:0] COUNT_FULL =
        pst_pkg::COUNT_W'(pst_pkg::MAX_ENTRIES);

    logic [2:0]                      state_reg, state_next;
    logic [pst_pkg::MAP_AW-1:0]      clr_ptr_reg, clr_ptr_next;
    logic [pst_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [pst_pkg::ACTION_W-1:0]    act_reg, act_next;
    logic [pst_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    pst_pkg::rsp_t                   res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    pst_pkg::rsp_t                   out_data_reg, out_data_next;

    // memory ports
    logic                            map_we;
    logic [pst_pkg::MAP_AW-1:0]      map_waddr;
    logic [pst_pkg::HANDLE_W-1:0]    map_wdata;
    logic [pst_pkg::MAP_AW-1:0]      map_raddr;
    logic [pst_pkg::HANDLE_W-1:0]    map_rdata;
    logic                            pk_we;
    logic [pst_pkg::SLOT_W-1:0]      pk_waddr;
    logic [pst_pkg::ID_W-1:0]        pk_wdata;
    logic [pst_pkg::SLOT_W-1:0]      pk_raddr;
    logic [pst_pkg::ID_W-1:0]        pk_rdata;

    logic                            req_fire;
    logic                            bad_handle;
    logic [pst_pkg::HANDLE_W-1:0]    handle_m1;
    logic [pst_pkg::COUNT_W-1:0]     count_m1;
    logic [pst_pkg::COUNT_W-1:0]     count_p1;
    logic                            out_free;

    // id to handle map
    pst_ram #(
        .WIDTH (pst_pkg::HANDLE_W),
        .DEPTH (pst_pkg::ID_SPACE)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // densely packed ids
    pst_ram #(
        .WIDTH (pst_pkg::ID_W),
        .DEPTH (pst_pkg::MAX_ENTRIES)
    ) u_packed_ram (
        .clk   (clk),
        .we    (pk_we),
        .waddr (pk_waddr),
        .wdata (pk_wdata),
        .raddr (pk_raddr),
        .rdata (pk_rdata)
    );

    // handshake and common terms
    assign req_ready  = (state_reg == S_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign handle_m1  = req.handle_in - pst_pkg::HANDLE_W'(1);
    assign count_m1   = count_reg - pst_pkg::COUNT_W'(1);
    assign count_p1   = count_reg + pst_pkg::COUNT_W'(1);
    assign bad_handle = (req.handle_in == '0) || (req.handle_in > count_reg);
    assign out_free   = !out_valid_reg || rsp_ready;

    // sequencer: read, modify and write back the two memories
    always_comb
    begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        count_next   = count_reg;
        act_next     = act_reg;
        slot_next    = slot_reg;
        res_next     = res_reg;

        map_we    = 1'b0;
        map_waddr = req.entity_id[pst_pkg::MAP_AW-1:0];
        map_wdata = '0;
        map_raddr = req.entity_id[pst_pkg::MAP_AW-1:0];
        pk_we     = 1'b0;
        pk_waddr  = count_reg[pst_pkg::SLOT_W-1:0];
        pk_wdata  = req.entity_id;
        pk_raddr  = handle_m1[pst_pkg::SLOT_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                map_we       = 1'b1;
                map_waddr    = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + pst_pkg::MAP_AW'(1);
                if (clr_ptr_reg == MAP_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    act_next  = req.action;
                    slot_next = handle_m1[pst_pkg::SLOT_W-1:0];
                    res_next  = '0;
                    unique case (req.action)
                        pst_pkg::ACT_REGISTER:
                        begin
                            if (count_reg == COUNT_FULL)
                            begin
                                res_next.status = pst_pkg::ST_FULL;
                            end
                            else
                            begin
                                // append id and map it to the new handle
                                pk_we               = 1'b1;
                                map_we              = 1'b1;
                                map_wdata           = count_p1;
                                count_next          = count_p1;
                                res_next.handle_out = count_p1;
                            end
                            state_next = S_RESP;
                        end
                        pst_pkg::ACT_FIND:
                        begin
                            state_next = S_LOOK;
                        end
                        pst_pkg::ACT_GET:
                        begin
                            if (bad_handle)
                            begin
                                res_next.status = pst_pkg::ST_BAD_HANDLE;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        pst_pkg::ACT_DESTROY:
                        begin
                            if (bad_handle)
                            begin
                                res_next.status = pst_pkg::ST_BAD_HANDLE;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DEST1;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                if (act_reg == pst_pkg::ACT_FIND)
                begin
                    res_next.handle_out = map_rdata;
                end
                else
                begin
                    res_next.entity_out = pk_rdata;
                end
                state_next = S_RESP;
            end

            S_DEST1:
            begin
                // unmap the victim id, fetch the last entry
                map_we     = 1'b1;
                map_waddr  = pk_rdata[pst_pkg::MAP_AW-1:0];
                pk_raddr   = count_m1[pst_pkg::SLOT_W-1:0];
                state_next = S_DEST2;
            end

            S_DEST2:
            begin
                // move the last entry into the freed slot and remap it
                if (pst_pkg::COUNT_W'(slot_reg) < count_m1)
                begin
                    pk_we     = 1'b1;
                    pk_waddr  = slot_reg;
                    pk_wdata  = pk_rdata;
                    map_we    = 1'b1;
                    map_waddr = pk_rdata[pst_pkg::MAP_AW-1:0];
                    map_wdata = pst_pkg::HANDLE_W'(slot_reg) + pst_pkg::HANDLE_W'(1);
                end
                count_next = count_m1;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_RESP) && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_ptr_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        slot_reg     <= slot_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count above table size");

    // a register into a non-full table grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.action == pst_pkg::ACT_REGISTER) && (count_reg != COUNT_FULL))
        |=> (count_reg == $past(count_p1)))
        else $error("register did not grow the count");

    // the remove step shrinks the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEST2) |=> (count_reg == $past(count_m1)))
        else $error("destroy did not shrink the count");

    // the clearing pass touches only the map
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!pk_we && map_we && (map_wdata == '0)))
        else $error("clearing pass wrote unexpected data");

endmodule

// File: src/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pst_ram #(
    parameter int WIDTH = pst_pkg::ID_W,
    parameter int DEPTH = pst_pkg::MAX_ENTRIES
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
